// ===== src/ctos_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctos_pkg
// Shared types, constants and helpers for the center-out tile scheduler.
// ----------------------------------------------------------------------------
package ctos_pkg;

   // sizes
   localparam int MAX_TILES = 1024;
   localparam int MAX_DIM   = 8192;
   localparam int DIM_W     = 14;
   localparam int COORD_W   = 13;
   localparam int SPP_W     = 16;
   localparam int IDX_W     = $clog2(MAX_TILES);
   localparam int CNT_W     = IDX_W + 1;
   localparam int MUL_W     = 16;
   localparam int PROD_W    = 2 * MUL_W;
   localparam int SQ_W      = 28;
   localparam int KEY_W     = SQ_W + 1;
   localparam int TOTAL_W   = 28;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 16;

   typedef enum logic [0:0] {
      OP_BUILD = 1'b0,
      OP_READ  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_OVERFLOW = 2'd1,
      STATUS_RANGE    = 2'd2
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_FRAME_WIDTH  = 3'd0,
      REG_FRAME_HEIGHT = 3'd1,
      REG_TILE_WIDTH   = 3'd2,
      REG_TILE_HEIGHT  = 3'd3,
      REG_SAMPLES      = 3'd4
   } reg_index_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_RD,
      S_DIVX_GO,
      S_DIVX_WAIT,
      S_DIVY_GO,
      S_DIVY_WAIT,
      S_MUL,
      S_TOTAL,
      S_SEG,
      S_KEY_DX,
      S_KEY_DY,
      S_KEY_SUM,
      S_INS_RD,
      S_INS_CMP,
      S_INS_PUT,
      S_NEXT
   } state_type;

   typedef enum logic [1:0] {
      SEG_FULL,
      SEG_BOTTOM,
      SEG_RIGHT,
      SEG_CORNER
   } seg_type;

   typedef struct packed {
      logic             operation;
      logic [IDX_W-1:0] tile_index;
   } req_type;

   typedef struct packed {
      logic [COORD_W-1:0] start_x;
      logic [COORD_W-1:0] start_y;
      logic [DIM_W-1:0]   span_w;
      logic [DIM_W-1:0]   span_h;
      logic [SPP_W-1:0]   tile_samples;
      logic [CNT_W-1:0]   tile_total;
      status_type         status;
   } rsp_type;

   typedef struct packed {
      logic [DIM_W-1:0]   span_h;
      logic [DIM_W-1:0]   span_w;
      logic [COORD_W-1:0] start_y;
      logic [COORD_W-1:0] start_x;
   } tile_type;

   typedef struct packed {
      logic             done;
      logic [DIM_W-1:0] quotient;
      logic [DIM_W-1:0] remainder;
   } div_res_type;

   // clamp a dimension register to 1..MAX_DIM
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      r = v;
      if (v == '0) r = DIM_W'(1);
      else if (v > DIM_W'(MAX_DIM)) r = DIM_W'(MAX_DIM);
      return r;
   endfunction

endpackage

// ===== src/center_out_tile_scheduler_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// center_out_tile_scheduler_core
// Builds a tile list of the frame and keeps it sorted center-out.
// ----------------------------------------------------------------------------
// Usage: items arrive on req_* (valid/stall), results leave on rsp_* with one
// result per item. Registers on csr_* (valid/ready, always ready) are to be
// written only while the block is idle; the block itself does not enforce it.
// A read (operation 1) returns tile tile_index of the sorted list: the table
// read is registered, then state S_RD fills the output register; the block
// takes no new item until the result of the last is in the output register.
// A build (operation 0) runs two divisions, a tile count multiply, then one
// insertion per tile, in which every earlier tile with a larger key moves up
// one place. A build that overflows the table empties the list and answers
// with an overflow status without inserting any tile.
// All of it goes through one restoring divider, one 16x16 multiplier and one
// key/tile RAM pair. The block accepts no item while a build or read is busy.
// Reset restores the register defaults and empties the list; tile memory is
// not cleared, only entries below the tile count are ever returned.
// The result sits in an output register; while rsp_stall is high it holds,
// and no new item is accepted until it is taken.
// ----------------------------------------------------------------------------
module center_out_tile_scheduler_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  ctos_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output ctos_pkg::rsp_type                 rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [ctos_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ctos_pkg::CSR_DAT_W-1:0]    csr_data
);

   localparam int DW = ctos_pkg::DIM_W;
   localparam int AW = ctos_pkg::IDX_W;
   localparam int CW = ctos_pkg::CNT_W;

   // configuration registers
   logic [DW-1:0]              fw_reg_ff, fh_reg_ff, tw_reg_ff, th_reg_ff;
   logic [ctos_pkg::SPP_W-1:0] spp_ff;

   // sequencer and datapath registers
   ctos_pkg::state_type        state_ff, state_in;
   ctos_pkg::seg_type          seg_ff, seg_in;
   logic [DW-1:0]              xt_ff, xt_in, xr_ff, xr_in;
   logic [DW-1:0]              yt_ff, yt_in, yr_ff, yr_in;
   logic [DW-1:0]              cx_ff, cx_in, cy_ff, cy_in;
   logic [DW-1:0]              px_ff, px_in, py_ff, py_in;
   logic [CW-1:0]              count_ff, count_in;
   logic [CW-1:0]              tally_ff, tally_in;
   logic [AW-1:0]              i_ff, i_in;
   logic [ctos_pkg::KEY_W-1:0] key_ff, key_in;
   logic signed [ctos_pkg::PROD_W-1:0] mul_ff, mul_in;
   logic                       range_ff, range_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   ctos_pkg::rsp_type          rsp_data_ff, rsp_data_in;

   // combinational helpers
   logic [DW-1:0]              cfw, cfh, ctw, cth;
   logic                       req_acc;
   logic                       div_start;
   logic [DW-1:0]              div_dividend, div_divisor;
   ctos_pkg::div_res_type      div_res;
   logic signed [ctos_pkg::MUL_W-1:0] dx, dy, mul_a, mul_b;
   logic [ctos_pkg::TOTAL_W-1:0] total_sum;
   logic [DW-1:0]              seg_nx, seg_ny, seg_x0, seg_y0, seg_w, seg_h;
   logic                       seg_on;
   logic                       ram_wr_en;
   logic [AW-1:0]              ram_rd_addr;
   logic [ctos_pkg::KEY_W-1:0] key_wr_data, key_rd_data;
   ctos_pkg::tile_type         tile_wr_data, tile_rd_data, tile_new;

   // clamped dimensions
   always_comb begin
      cfw = ctos_pkg::clamp_dim(fw_reg_ff);
      cfh = ctos_pkg::clamp_dim(fh_reg_ff);
      ctw = ctos_pkg::clamp_dim(tw_reg_ff);
      cth = ctos_pkg::clamp_dim(th_reg_ff);
   end

   // handshakes
   assign req_stall = (state_ff != ctos_pkg::S_IDLE) || (rsp_valid_ff && rsp_stall);
   assign req_acc   = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         fw_reg_ff <= DW'(640);
         fh_reg_ff <= DW'(480);
         tw_reg_ff <= DW'(32);
         th_reg_ff <= DW'(32);
         spp_ff    <= ctos_pkg::SPP_W'(1);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            ctos_pkg::REG_FRAME_WIDTH:  fw_reg_ff <= csr_data[DW-1:0];
            ctos_pkg::REG_FRAME_HEIGHT: fh_reg_ff <= csr_data[DW-1:0];
            ctos_pkg::REG_TILE_WIDTH:   tw_reg_ff <= csr_data[DW-1:0];
            ctos_pkg::REG_TILE_HEIGHT:  th_reg_ff <= csr_data[DW-1:0];
            ctos_pkg::REG_SAMPLES:      spp_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   // shared divider
   assign div_start    = (state_ff == ctos_pkg::S_DIVX_GO) ||
                         (state_ff == ctos_pkg::S_DIVY_GO);
   assign div_dividend = (state_ff == ctos_pkg::S_DIVX_GO) ? cfw : cfh;
   assign div_divisor  = (state_ff == ctos_pkg::S_DIVX_GO) ? ctw : cth;

   ctos_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .res      (div_res)
   );

   // shared multiplier operands
   always_comb begin
      dx = $signed({1'b0, px_ff, 1'b0}) - $signed({2'b00, cfw});
      dy = $signed({1'b0, py_ff, 1'b0}) - $signed({2'b00, cfh});
      case (state_ff)
         ctos_pkg::S_MUL: begin
            mul_a = $signed({2'b00, xt_ff});
            mul_b = $signed({2'b00, yt_ff});
         end
         ctos_pkg::S_KEY_DY: begin
            mul_a = dy;
            mul_b = dy;
         end
         default: begin
            mul_a = dx;
            mul_b = dx;
         end
      endcase
   end

   // tile count with remainder row, column and corner
   always_comb begin
      total_sum = mul_ff[ctos_pkg::TOTAL_W-1:0];
      if (yr_ff != '0) total_sum = total_sum + ctos_pkg::TOTAL_W'(xt_ff);
      if (xr_ff != '0) total_sum = total_sum + ctos_pkg::TOTAL_W'(yt_ff);
      if (xr_ff != '0 && yr_ff != '0) total_sum = total_sum + ctos_pkg::TOTAL_W'(1);
   end

   // segment geometry
   always_comb begin
      case (seg_ff)
         ctos_pkg::SEG_FULL: begin
            seg_nx = xt_ff;
            seg_ny = yt_ff;
            seg_x0 = '0;
            seg_y0 = '0;
            seg_w  = ctw;
            seg_h  = cth;
         end
         ctos_pkg::SEG_BOTTOM: begin
            seg_nx = (yr_ff != '0) ? xt_ff : '0;
            seg_ny = DW'(1);
            seg_x0 = '0;
            seg_y0 = cfh - yr_ff;
            seg_w  = ctw;
            seg_h  = yr_ff;
         end
         ctos_pkg::SEG_RIGHT: begin
            seg_nx = (xr_ff != '0) ? DW'(1) : '0;
            seg_ny = yt_ff;
            seg_x0 = cfw - xr_ff;
            seg_y0 = '0;
            seg_w  = xr_ff;
            seg_h  = cth;
         end
         default: begin
            seg_nx = (xr_ff != '0 && yr_ff != '0) ? DW'(1) : '0;
            seg_ny = DW'(1);
            seg_x0 = cfw - xr_ff;
            seg_y0 = cfh - yr_ff;
            seg_w  = xr_ff;
            seg_h  = yr_ff;
         end
      endcase
      seg_on = (seg_nx != '0) && (seg_ny != '0);
   end

   // tile under construction
   always_comb begin
      tile_new.span_h  = seg_h;
      tile_new.span_w  = seg_w;
      tile_new.start_y = py_ff[ctos_pkg::COORD_W-1:0];
      tile_new.start_x = px_ff[ctos_pkg::COORD_W-1:0];
   end

   // memory ports: shift on larger key, place new tile
   always_comb begin
      ram_wr_en    = 1'b0;
      key_wr_data  = key_ff;
      tile_wr_data = tile_new;
      if (state_ff == ctos_pkg::S_INS_CMP && key_rd_data > key_ff) begin
         ram_wr_en    = 1'b1;
         key_wr_data  = key_rd_data;
         tile_wr_data = tile_rd_data;
      end else if (state_ff == ctos_pkg::S_INS_PUT) begin
         ram_wr_en = 1'b1;
      end
      ram_rd_addr = (state_ff == ctos_pkg::S_IDLE) ? req_data.tile_index : i_ff - AW'(1);
   end

   ctos_ram #(
      .WIDTH (ctos_pkg::KEY_W),
      .DEPTH (ctos_pkg::MAX_TILES)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (i_ff),
      .wr_data (key_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (key_rd_data)
   );

   ctos_ram #(
      .WIDTH ($bits(ctos_pkg::tile_type)),
      .DEPTH (ctos_pkg::MAX_TILES)
   ) u_tile_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (i_ff),
      .wr_data (tile_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (tile_rd_data)
   );

   // sequencer: next state and datapath updates
   always_comb begin
      state_in     = state_ff;
      seg_in       = seg_ff;
      xt_in        = xt_ff;
      xr_in        = xr_ff;
      yt_in        = yt_ff;
      yr_in        = yr_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      count_in     = count_ff;
      tally_in     = tally_ff;
      i_in         = i_ff;
      key_in       = key_ff;
      mul_in       = mul_a * mul_b;
      range_in     = range_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      case (state_ff)
         ctos_pkg::S_IDLE: begin
            if (req_acc) begin
               if (req_data.operation == ctos_pkg::OP_BUILD) begin
                  state_in = ctos_pkg::S_DIVX_GO;
               end else begin
                  range_in = {1'b0, req_data.tile_index} >= tally_ff;
                  state_in = ctos_pkg::S_RD;
               end
            end
         end
         ctos_pkg::S_RD: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = '0;
            rsp_data_in.tile_total = tally_ff;
            if (range_ff) begin
               rsp_data_in.status = ctos_pkg::STATUS_RANGE;
            end else begin
               rsp_data_in.start_x      = tile_rd_data.start_x;
               rsp_data_in.start_y      = tile_rd_data.start_y;
               rsp_data_in.span_w       = tile_rd_data.span_w;
               rsp_data_in.span_h       = tile_rd_data.span_h;
               rsp_data_in.tile_samples = spp_ff;
               rsp_data_in.status       = ctos_pkg::STATUS_OK;
            end
            state_in = ctos_pkg::S_IDLE;
         end
         ctos_pkg::S_DIVX_GO: state_in = ctos_pkg::S_DIVX_WAIT;
         ctos_pkg::S_DIVX_WAIT: begin
            if (div_res.done) begin
               xt_in    = div_res.quotient;
               xr_in    = div_res.remainder;
               state_in = ctos_pkg::S_DIVY_GO;
            end
         end
         ctos_pkg::S_DIVY_GO: state_in = ctos_pkg::S_DIVY_WAIT;
         ctos_pkg::S_DIVY_WAIT: begin
            if (div_res.done) begin
               yt_in    = div_res.quotient;
               yr_in    = div_res.remainder;
               state_in = ctos_pkg::S_MUL;
            end
         end
         ctos_pkg::S_MUL: state_in = ctos_pkg::S_TOTAL;
         ctos_pkg::S_TOTAL: begin
            if (total_sum > ctos_pkg::TOTAL_W'(ctos_pkg::MAX_TILES)) begin
               // list too long: empty it and flag the build
               tally_in     = '0;
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               rsp_data_in.status = ctos_pkg::STATUS_OVERFLOW;
               state_in     = ctos_pkg::S_IDLE;
            end else begin
               count_in = '0;
               seg_in   = ctos_pkg::SEG_FULL;
               state_in = ctos_pkg::S_SEG;
            end
         end
         ctos_pkg::S_SEG: begin
            if (seg_on) begin
               px_in    = seg_x0;
               py_in    = seg_y0;
               cx_in    = '0;
               cy_in    = '0;
               state_in = ctos_pkg::S_KEY_DX;
            end else if (seg_ff == ctos_pkg::SEG_CORNER) begin
               tally_in     = count_ff;
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               rsp_data_in.tile_total = count_ff;
               rsp_data_in.status     = ctos_pkg::STATUS_OK;
               state_in     = ctos_pkg::S_IDLE;
            end else begin
               seg_in = ctos_pkg::seg_type'(seg_ff + 2'd1);
            end
         end
         ctos_pkg::S_KEY_DX: state_in = ctos_pkg::S_KEY_DY;
         ctos_pkg::S_KEY_DY: begin
            key_in   = {1'b0, mul_ff[ctos_pkg::SQ_W-1:0]};
            state_in = ctos_pkg::S_KEY_SUM;
         end
         ctos_pkg::S_KEY_SUM: begin
            key_in   = key_ff + {1'b0, mul_ff[ctos_pkg::SQ_W-1:0]};
            i_in     = count_ff[AW-1:0];
            state_in = ctos_pkg::S_INS_RD;
         end
         ctos_pkg::S_INS_RD: begin
            state_in = (i_ff == '0) ? ctos_pkg::S_INS_PUT : ctos_pkg::S_INS_CMP;
         end
         ctos_pkg::S_INS_CMP: begin
            // strictly larger keys move up, equal keys keep build order
            if (key_rd_data > key_ff) begin
               i_in     = i_ff - AW'(1);
               state_in = ctos_pkg::S_INS_RD;
            end else begin
               state_in = ctos_pkg::S_INS_PUT;
            end
         end
         ctos_pkg::S_INS_PUT: begin
            count_in = count_ff + CW'(1);
            state_in = ctos_pkg::S_NEXT;
         end
         ctos_pkg::S_NEXT: begin
            if (cx_ff + DW'(1) != seg_nx) begin
               cx_in    = cx_ff + DW'(1);
               px_in    = px_ff + ctw;
               state_in = ctos_pkg::S_KEY_DX;
            end else if (cy_ff + DW'(1) != seg_ny) begin
               cx_in    = '0;
               px_in    = seg_x0;
               cy_in    = cy_ff + DW'(1);
               py_in    = py_ff + cth;
               state_in = ctos_pkg::S_KEY_DX;
            end else if (seg_ff == ctos_pkg::SEG_CORNER) begin
               tally_in     = count_ff;
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               rsp_data_in.tile_total = count_ff;
               rsp_data_in.status     = ctos_pkg::STATUS_OK;
               state_in     = ctos_pkg::S_IDLE;
            end else begin
               seg_in   = ctos_pkg::seg_type'(seg_ff + 2'd1);
               state_in = ctos_pkg::S_SEG;
            end
         end
         default: state_in = ctos_pkg::S_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ctos_pkg::S_IDLE;
         tally_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tally_ff     <= tally_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      seg_ff      <= seg_in;
      xt_ff       <= xt_in;
      xr_ff       <= xr_in;
      yt_ff       <= yt_in;
      yr_ff       <= yr_in;
      cx_ff       <= cx_in;
      cy_ff       <= cy_in;
      px_ff       <= px_in;
      py_ff       <= py_in;
      count_ff    <= count_in;
      i_ff        <= i_in;
      key_ff      <= key_in;
      mul_ff      <= mul_in;
      range_ff    <= range_in;
      rsp_data_ff <= rsp_data_in;
   end

`ifndef SYNTHESIS
   // list never exceeds the table
   assert property (@(posedge clock) disable iff (reset)
      tally_ff <= CW'(ctos_pkg::MAX_TILES))
      else $error("tile count beyond table size");

   // an insertion only happens while the table has room
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ctos_pkg::S_INS_PUT |-> count_ff < CW'(ctos_pkg::MAX_TILES))
      else $error("insertion into full table");

   // a read transfer moves the sequencer to the table read state on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_acc && req_data.operation == ctos_pkg::OP_READ |=> state_ff == ctos_pkg::S_RD)
      else $error("read transfer not followed by table read");

   // divider finishes only while the sequencer waits for it
   assert property (@(posedge clock) disable iff (reset)
      div_res.done |-> (state_ff == ctos_pkg::S_DIVX_WAIT ||
                        state_ff == ctos_pkg::S_DIVY_WAIT))
      else $error("divider result outside wait state");
`endif

endmodule

// ===== src/ctos_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctos_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ctos_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== src/ctos_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctos_div
// Restoring divider, one quotient bit per cycle, quotient and remainder out.
// ----------------------------------------------------------------------------
module ctos_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [ctos_pkg::DIM_W-1:0]     dividend,
   input  logic [ctos_pkg::DIM_W-1:0]     divisor,
   output ctos_pkg::div_res_type          res
);

   localparam int CNT_BITS = $clog2(ctos_pkg::DIM_W + 1);

   logic                       busy_ff, busy_in;
   logic [CNT_BITS-1:0]        cnt_ff, cnt_in;
   logic [ctos_pkg::DIM_W-1:0] rem_ff, rem_in;
   logic [ctos_pkg::DIM_W-1:0] quo_ff, quo_in;
   logic [ctos_pkg::DIM_W-1:0] dsr_ff, dsr_in;
   logic [ctos_pkg::DIM_W:0]   shifted;
   logic [ctos_pkg::DIM_W:0]   diff;
   logic                       ge;

   // one trial subtraction per cycle
   always_comb begin
      shifted = {rem_ff, quo_ff[ctos_pkg::DIM_W-1]};
      ge      = shifted >= {1'b0, dsr_ff};
      diff    = shifted - {1'b0, dsr_ff};
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_BITS'(ctos_pkg::DIM_W);
         rem_in  = '0;
         quo_in  = dividend;
         dsr_in  = divisor;
      end else if (busy_ff && cnt_ff != '0) begin
         cnt_in = cnt_ff - CNT_BITS'(1);
         rem_in = ge ? diff[ctos_pkg::DIM_W-1:0] : shifted[ctos_pkg::DIM_W-1:0];
         quo_in = {quo_ff[ctos_pkg::DIM_W-2:0], ge};
      end else if (busy_ff) begin
         busy_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign res.done      = busy_ff && (cnt_ff == '0);
   assign res.quotient  = quo_ff;
   assign res.remainder = rem_ff;

endmodule
